[hw/rtl/rwl_pkg.sv]
// ----------------------------------------------------------------------------
// rwl_pkg: shared definitions for the reader/writer lock manager
// Request kinds, status codes, field widths, parameter defaults and the
// command bundle from the controller to the datapath.
// ----------------------------------------------------------------------------
package rwl_pkg;

    // Fixed field widths of the request and result channels.
    localparam int REQ_TYPE_W = 4;
    localparam int ID_W       = 8;
    localparam int STATUS_W   = 3;
    localparam int READERS_W  = 8;

    // Parameter defaults.
    localparam int DEF_MAX_READERS   = 255;
    localparam int DEF_MAX_RECURSION = 255;
    localparam int DEF_ID_BITS       = 8;

    // Request kinds.
    localparam logic [REQ_TYPE_W-1:0] REQ_READ            = 4'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_WRITE           = 4'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_WRITE_POLL      = 4'd2;
    localparam logic [REQ_TYPE_W-1:0] REQ_RELEASE         = 4'd3;
    localparam logic [REQ_TYPE_W-1:0] REQ_UPGRADE         = 4'd4;
    localparam logic [REQ_TYPE_W-1:0] REQ_UPGRADE_POLL    = 4'd5;
    localparam logic [REQ_TYPE_W-1:0] REQ_DOWNGRADE       = 4'd6;
    localparam logic [REQ_TYPE_W-1:0] REQ_TRY_WRITE       = 4'd7;
    localparam logic [REQ_TYPE_W-1:0] REQ_TRY_READ        = 4'd8;
    localparam logic [REQ_TYPE_W-1:0] REQ_TRY_UPGRADE     = 4'd9;
    localparam logic [REQ_TYPE_W-1:0] REQ_SET_RECURSIVE   = 4'd10;
    localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR_RECURSIVE = 4'd11;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_GRANTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BUSY     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DRAINING = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REFUSED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ERROR    = 3'd4;

    // Command from the controller: commit one request to the lock state
    // and load its result into the output register.
    typedef struct packed {
        logic commit;
    } rwl_cmd_t;

endpackage

[hw/rtl/reader_writer_lock_manager_core.sv]
// Latency: a result is valid in the cycle after its request is accepted.
// Throughput: one request per cycle unless a held result is not taken;
// the lock registers are read, updated and written back on acceptance, and
// the result register lets the next request in while the last is taken.
// Reset (aresetn low, synchronous): all lock state and sleep_allowed clear,
// no result is pending.
// ----------------------------------------------------------------------------
// reader_writer_lock_manager_core: reader/writer lock with upgrade
// Top level joining the handshake controller and the lock datapath.
// ----------------------------------------------------------------------------
module reader_writer_lock_manager_core #(
    parameter int MAX_READERS   = rwl_pkg::DEF_MAX_READERS,
    parameter int MAX_RECURSION = rwl_pkg::DEF_MAX_RECURSION,
    parameter int ID_BITS       = rwl_pkg::DEF_ID_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic                           cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [rwl_pkg::REQ_TYPE_W-1:0] s_req_type,
    input  logic [rwl_pkg::ID_W-1:0]       s_requester_id,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [rwl_pkg::STATUS_W-1:0]   m_status,
    output logic                           m_wake_waiters,
    output logic [rwl_pkg::READERS_W-1:0]  m_readers_now,
    output logic                           m_write_held,
    output logic                           m_upgrade_held
);
    import rwl_pkg::*;

    rwl_cmd_t cmd;

    rwl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    rwl_datapath #(
        .MAX_READERS   (MAX_READERS),
        .MAX_RECURSION (MAX_RECURSION),
        .ID_BITS       (ID_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .req_type     (s_req_type),
        .requester_id (s_requester_id),
        .status       (m_status),
        .wake_waiters (m_wake_waiters),
        .readers_now  (m_readers_now),
        .write_held   (m_write_held),
        .upgrade_held (m_upgrade_held)
    );

endmodule

[hw/rtl/rwl_ctrl.sv]
// ----------------------------------------------------------------------------
// rwl_ctrl: handshake controller
// Tracks whether the result register holds an untaken result and decides
// when a new request may be accepted and committed.
// ----------------------------------------------------------------------------
module rwl_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output rwl_pkg::rwl_cmd_t cmd
);
    import rwl_pkg::*;

    localparam logic OUT_EMPTY = 1'b0;
    localparam logic OUT_FULL  = 1'b1;

    logic state_reg;
    logic state_next;
    logic accept;

    // A held result that is taken in this cycle frees the slot for a new one.
    assign s_ready    = (state_reg == OUT_EMPTY) || m_ready;
    assign accept     = s_valid && s_ready;
    assign m_valid    = (state_reg == OUT_FULL);
    assign cmd.commit = accept;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            OUT_EMPTY: begin
                if (accept) state_next = OUT_FULL;
            end
            OUT_FULL: begin
                if (accept) state_next = OUT_FULL;
                else if (m_ready) state_next = OUT_EMPTY;
            end
            default: state_next = OUT_EMPTY;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= OUT_EMPTY;
        end else begin
            state_reg <= state_next;
        end
    end

    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted request did not produce a result");

    a_taken_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !accept) |=> !m_valid)
        else $error("taken result was presented again");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("request stalled while the result slot was empty");

endmodule

[hw/rtl/rwl_datapath.sv]
// ----------------------------------------------------------------------------
// rwl_datapath: lock state and request evaluation
// Holds the reader count, intent bits, sleeper mark, recursive owner and
// depth, evaluates one request against them and registers its result.
// ----------------------------------------------------------------------------
module rwl_datapath #(
    parameter int MAX_READERS   = rwl_pkg::DEF_MAX_READERS,
    parameter int MAX_RECURSION = rwl_pkg::DEF_MAX_RECURSION,
    parameter int ID_BITS       = rwl_pkg::DEF_ID_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  rwl_pkg::rwl_cmd_t              cmd,
    input  logic                           cfg_wr_en,
    input  logic                           cfg_wr_data,
    input  logic [rwl_pkg::REQ_TYPE_W-1:0] req_type,
    input  logic [rwl_pkg::ID_W-1:0]       requester_id,
    output logic [rwl_pkg::STATUS_W-1:0]   status,
    output logic                           wake_waiters,
    output logic [rwl_pkg::READERS_W-1:0]  readers_now,
    output logic                           write_held,
    output logic                           upgrade_held
);
    import rwl_pkg::*;

    localparam int RD_W  = $clog2(MAX_READERS + 1);
    localparam int REC_W = $clog2(MAX_RECURSION + 1);

    localparam logic [RD_W-1:0]  RD_MAX  = RD_W'(MAX_READERS);
    localparam logic [REC_W-1:0] REC_MAX = REC_W'(MAX_RECURSION);
    localparam logic [RD_W-1:0]  RD_ONE  = RD_W'(1);
    localparam logic [REC_W-1:0] REC_ONE = REC_W'(1);

    logic               sleep_allowed_reg;
    logic [RD_W-1:0]    reader_count_reg, reader_count_next;
    logic               write_intent_reg, write_intent_next;
    logic               upgrade_intent_reg, upgrade_intent_next;
    logic               sleepers_reg, sleepers_next;
    logic               owner_valid_reg, owner_valid_next;
    logic [ID_BITS-1:0] owner_id_reg, owner_id_next;
    logic [REC_W-1:0]   depth_reg, depth_next;

    logic [STATUS_W-1:0]  status_reg, status_next;
    logic                 wake_reg, wake_next;
    logic [READERS_W-1:0] readers_reg, readers_next;
    logic                 write_out_reg;
    logic                 upgrade_out_reg;

    logic [ID_BITS-1:0] who;
    logic               owner;
    logic               rd_full;
    logic               rec_full;
    logic               any_intent;

    // The requester is matched on its low ID_BITS bits, zero-extended when ID_BITS exceeds ID_W.
    generate
        if (ID_BITS <= ID_W) begin : g_who_trunc
            assign who = requester_id[ID_BITS-1:0];
        end else begin : g_who_ext
            assign who = {{(ID_BITS - ID_W){1'b0}}, requester_id};
        end
        if (RD_W >= READERS_W) begin : g_rd_trunc
            assign readers_next = reader_count_next[READERS_W-1:0];
        end else begin : g_rd_ext
            assign readers_next = {{(READERS_W - RD_W){1'b0}}, reader_count_next};
        end
    endgenerate

    assign owner      = owner_valid_reg && (owner_id_reg == who);
    assign rd_full    = (reader_count_reg >= RD_MAX);
    assign rec_full   = (depth_reg >= REC_MAX);
    assign any_intent = write_intent_reg || upgrade_intent_reg;

    always_comb begin
        reader_count_next   = reader_count_reg;
        write_intent_next   = write_intent_reg;
        upgrade_intent_next = upgrade_intent_reg;
        sleepers_next       = sleepers_reg;
        owner_valid_next    = owner_valid_reg;
        owner_id_next       = owner_id_reg;
        depth_next          = depth_reg;
        status_next         = ST_ERROR;
        wake_next           = 1'b0;

        case (req_type)
            REQ_READ, REQ_TRY_READ: begin
                if (!owner && any_intent) begin
                    if (req_type == REQ_READ) begin
                        status_next = ST_BUSY;
                        if (sleep_allowed_reg) sleepers_next = 1'b1;
                    end else begin
                        status_next = ST_REFUSED;
                    end
                end else if (!rd_full) begin
                    reader_count_next = reader_count_reg + RD_ONE;
                    status_next       = ST_GRANTED;
                end
            end
            REQ_WRITE, REQ_TRY_WRITE: begin
                if (owner) begin
                    if (!rec_full) begin
                        depth_next  = depth_reg + REC_ONE;
                        status_next = ST_GRANTED;
                    end
                end else if (write_intent_reg) begin
                    if (req_type == REQ_WRITE) begin
                        status_next = ST_BUSY;
                        if (sleep_allowed_reg) sleepers_next = 1'b1;
                    end else begin
                        status_next = ST_REFUSED;
                    end
                end else if ((reader_count_reg != '0) || upgrade_intent_reg) begin
                    if (req_type == REQ_WRITE) begin
                        write_intent_next = 1'b1;
                        status_next       = ST_DRAINING;
                        if (sleep_allowed_reg) sleepers_next = 1'b1;
                    end else begin
                        status_next = ST_REFUSED;
                    end
                end else begin
                    write_intent_next = 1'b1;
                    status_next       = ST_GRANTED;
                end
            end
            REQ_WRITE_POLL: begin
                if (!write_intent_reg) begin
                    status_next = ST_REFUSED;
                end else if ((reader_count_reg != '0) || upgrade_intent_reg) begin
                    status_next = ST_DRAINING;
                    if (sleep_allowed_reg) sleepers_next = 1'b1;
                end else begin
                    status_next = ST_GRANTED;
                end
            end
            REQ_RELEASE: begin
                // Drop the innermost hold: a reader, a recursion level, then
                // upgrade intent, then write intent.
                if (reader_count_reg != '0 || depth_reg != '0 || any_intent) begin
                    status_next = ST_GRANTED;
                    if (reader_count_reg != '0) begin
                        reader_count_next = reader_count_reg - RD_ONE;
                    end else if (depth_reg != '0) begin
                        depth_next = depth_reg - REC_ONE;
                    end else if (upgrade_intent_reg) begin
                        upgrade_intent_next = 1'b0;
                    end else begin
                        write_intent_next = 1'b0;
                    end
                    if (sleepers_reg && (reader_count_next == '0)) begin
                        sleepers_next = 1'b0;
                        wake_next     = 1'b1;
                    end
                end
            end
            REQ_UPGRADE, REQ_TRY_UPGRADE: begin
                if (reader_count_reg != '0) begin
                    if (owner) begin
                        if (!rec_full) begin
                            reader_count_next = reader_count_reg - RD_ONE;
                            depth_next        = depth_reg + REC_ONE;
                            status_next       = ST_GRANTED;
                        end
                    end else if (upgrade_intent_reg) begin
                        // A refused blocking upgrade still gives up its reader.
                        status_next = ST_REFUSED;
                        if (req_type == REQ_UPGRADE) begin
                            reader_count_next = reader_count_reg - RD_ONE;
                            if (sleepers_reg && (reader_count_next == '0)) begin
                                sleepers_next = 1'b0;
                                wake_next     = 1'b1;
                            end
                        end
                    end else begin
                        upgrade_intent_next = 1'b1;
                        reader_count_next   = reader_count_reg - RD_ONE;
                        if (reader_count_next != '0) begin
                            status_next = ST_DRAINING;
                            if (sleep_allowed_reg) sleepers_next = 1'b1;
                        end else begin
                            status_next = ST_GRANTED;
                        end
                    end
                end
            end
            REQ_UPGRADE_POLL: begin
                if (!upgrade_intent_reg) begin
                    status_next = ST_REFUSED;
                end else if (reader_count_reg != '0) begin
                    status_next = ST_DRAINING;
                    if (sleep_allowed_reg) sleepers_next = 1'b1;
                end else begin
                    status_next = ST_GRANTED;
                end
            end
            REQ_DOWNGRADE: begin
                if (!rd_full && (depth_reg != '0 || any_intent)) begin
                    if (depth_reg != '0) begin
                        depth_next = depth_reg - REC_ONE;
                    end else if (upgrade_intent_reg) begin
                        upgrade_intent_next = 1'b0;
                    end else begin
                        write_intent_next = 1'b0;
                    end
                    reader_count_next = reader_count_reg + RD_ONE;
                    status_next       = ST_GRANTED;
                    if (sleepers_reg) begin
                        sleepers_next = 1'b0;
                        wake_next     = 1'b1;
                    end
                end
            end
            REQ_SET_RECURSIVE: begin
                if (write_intent_reg) begin
                    owner_valid_next = 1'b1;
                    owner_id_next    = who;
                    status_next      = ST_GRANTED;
                end
            end
            REQ_CLEAR_RECURSIVE: begin
                if (owner) begin
                    if (depth_reg == '0) owner_valid_next = 1'b0;
                    status_next = ST_GRANTED;
                end
            end
            default: begin
                status_next = ST_ERROR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sleep_allowed_reg  <= 1'b0;
            reader_count_reg   <= '0;
            write_intent_reg   <= 1'b0;
            upgrade_intent_reg <= 1'b0;
            sleepers_reg       <= 1'b0;
            owner_valid_reg    <= 1'b0;
            owner_id_reg       <= '0;
            depth_reg          <= '0;
        end else begin
            if (cfg_wr_en) sleep_allowed_reg <= cfg_wr_data;
            if (cmd.commit) begin
                reader_count_reg   <= reader_count_next;
                write_intent_reg   <= write_intent_next;
                upgrade_intent_reg <= upgrade_intent_next;
                sleepers_reg       <= sleepers_next;
                owner_valid_reg    <= owner_valid_next;
                owner_id_reg       <= owner_id_next;
                depth_reg          <= depth_next;
            end
        end
    end

    // Result register; its valid bit lives in the controller.
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            status_reg      <= status_next;
            wake_reg        <= wake_next;
            readers_reg     <= readers_next;
            write_out_reg   <= write_intent_next;
            upgrade_out_reg <= upgrade_intent_next;
        end
    end

    assign status       = status_reg;
    assign wake_waiters = wake_reg;
    assign readers_now  = readers_reg;
    assign write_held   = write_out_reg;
    assign upgrade_held = upgrade_out_reg;

    a_counters_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (reader_count_reg <= RD_MAX) && (depth_reg <= REC_MAX))
        else $error("lock counter beyond its limit");

    a_error_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && (status_next == ST_ERROR)) |=>
            ($stable(reader_count_reg) && $stable(depth_reg) && $stable(write_intent_reg)
             && $stable(upgrade_intent_reg) && $stable(sleepers_reg)
             && $stable(owner_valid_reg)))
        else $error("request answered error but changed the lock state");

    a_wake_status: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> (!wake_reg || (status_reg == ST_GRANTED)
                        || (status_reg == ST_REFUSED)))
        else $error("wake pulse raised with a blocking or error status");

endmodule
